// ----- sv/fjkv_pkg.sv -----
// shared types and constants of the flat json key value scanner
package fjkv_pkg;

   // output field width fixed by the result word
   localparam int FIELD_BITS = 16;

   // result queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // characters of interest in the byte stream
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;

   // scanner modes
   typedef enum logic [1:0] {
      MODE_SEEK,
      MODE_KEY,
      MODE_VALUE
   } scan_mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_PAIR = 2'd0,
      STATUS_DONE = 2'd1,
      STATUS_OPEN_VALUE = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // one queue entry: a found pair, an end of message, or both
   typedef struct packed {
      logic has_pair;
      logic has_end;
      status_type end_status;
      logic [FIELD_BITS-1:0] pair_index;
      logic [FIELD_BITS-1:0] end_count;
      logic [FIELD_BITS-1:0] key_open;
      logic [FIELD_BITS-1:0] quote_pos;
      logic [FIELD_BITS-1:0] value_start;
      logic [FIELD_BITS-1:0] close_pos;
   } scan_cmd_type;

endpackage

// ----- sv/fjkv_req_if.sv -----
// input channel carrying one raw message byte per word
interface fjkv_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- sv/fjkv_rsp_if.sv -----
// result channel carrying one pair or end report per word
interface fjkv_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [15:0] pair_index;
   logic [15:0] key_offset;
   logic [15:0] key_length;
   logic [15:0] value_offset;
   logic [15:0] value_length;
   logic final_res;

   modport source (output valid, output status, output pair_index, output key_offset,
                   output key_length, output value_offset, output value_length,
                   output final_res, input ready);
   modport sink (input valid, input status, input pair_index, input key_offset,
                 input key_length, input value_offset, input value_length,
                 input final_res, output ready);
endinterface

// ----- sv/fjkv_front.sv -----
// front end: filters bytes, tracks the key and value scan, queues results
module fjkv_front #(
   parameter int POSITION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   fjkv_req_if.sink req,
   input  logic queue_full,
   output logic push,
   output fjkv_pkg::scan_cmd_type push_cmd
);
   import fjkv_pkg::*;

   localparam int EXT_BITS = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
   localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

   scan_mode_type mode_ff, mode_in;
   logic [POSITION_BITS-1:0] fpos_ff, fpos_in;
   logic [POSITION_BITS-1:0] kopen_ff, kopen_in;
   logic [POSITION_BITS-1:0] qcand_ff, qcand_in;
   logic [POSITION_BITS-1:0] vstart_ff, vstart_in;
   logic [FIELD_BITS-1:0] pcount_ff, pcount_in;
   logic ovf_ff, ovf_in;
   logic ended_ff, ended_in;
   logic pquote_ff, pquote_in;
   logic pqcolon_ff, pqcolon_in;

   logic accept;
   logic kept;
   logic has_pair;
   logic [POSITION_BITS-1:0] cur_pos;
   logic [7:0] c;

   // low field bits of a position, zero extended for narrow positions
   function automatic logic [FIELD_BITS-1:0] to_field(input logic [POSITION_BITS-1:0] x);
      logic [EXT_BITS-1:0] t;
      t = EXT_BITS'(x);
      return t[FIELD_BITS-1:0];
   endfunction

   assign req.ready = !queue_full;
   assign accept = req.valid && !queue_full;
   assign c = req.data_byte;
   assign kept = (c > CHAR_SPACE) && (c <= CHAR_TILDE);
   assign cur_pos = fpos_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SEEK;
         fpos_ff <= '0;
         kopen_ff <= '0;
         qcand_ff <= '0;
         vstart_ff <= '0;
         pcount_ff <= '0;
         ovf_ff <= 1'b0;
         ended_ff <= 1'b0;
         pquote_ff <= 1'b0;
         pqcolon_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         fpos_ff <= fpos_in;
         kopen_ff <= kopen_in;
         qcand_ff <= qcand_in;
         vstart_ff <= vstart_in;
         pcount_ff <= pcount_in;
         ovf_ff <= ovf_in;
         ended_ff <= ended_in;
         pquote_ff <= pquote_in;
         pqcolon_ff <= pqcolon_in;
      end
   end

   // next state and queue entry
   always_comb begin
      mode_in = mode_ff;
      fpos_in = fpos_ff;
      kopen_in = kopen_ff;
      qcand_in = qcand_ff;
      vstart_in = vstart_ff;
      pcount_in = pcount_ff;
      ovf_in = ovf_ff;
      ended_in = ended_ff;
      pquote_in = pquote_ff;
      pqcolon_in = pqcolon_ff;
      has_pair = 1'b0;

      if (accept && !ended_ff && !ovf_ff) begin
         if (c == CHAR_NUL) begin
            ended_in = 1'b1;
         end else if (kept) begin
            if (fpos_ff == POS_LIMIT) begin
               ovf_in = 1'b1;
            end else begin
               fpos_in = fpos_ff + 1'b1;
               unique case (mode_ff)
                  MODE_SEEK: begin
                     if (c == CHAR_QUOTE) begin
                        kopen_in = cur_pos;
                        pquote_in = 1'b0;
                        pqcolon_in = 1'b0;
                        mode_in = MODE_KEY;
                     end
                  end
                  MODE_KEY: begin
                     if (pqcolon_ff) begin
                        if (c == CHAR_LBRACE) begin
                           mode_in = MODE_SEEK;
                        end else begin
                           qcand_in = cur_pos - 2'd2;
                           vstart_in = cur_pos;
                           mode_in = MODE_VALUE;
                        end
                        pquote_in = 1'b0;
                        pqcolon_in = 1'b0;
                     end else begin
                        pqcolon_in = pquote_ff && (c == CHAR_COLON);
                        pquote_in = (c == CHAR_QUOTE);
                     end
                  end
                  MODE_VALUE: begin
                  end
                  default: begin
                     mode_in = MODE_SEEK;
                  end
               endcase
               // a comma or closing brace ends the value
               if (mode_in == MODE_VALUE && (c == CHAR_COMMA || c == CHAR_RBRACE)) begin
                  has_pair = 1'b1;
                  pcount_in = pcount_ff + 1'b1;
                  mode_in = MODE_SEEK;
               end
            end
         end
      end

      push_cmd.has_pair = has_pair;
      push_cmd.has_end = req.last_byte;
      if (ovf_in) begin
         push_cmd.end_status = STATUS_OVERFLOW;
      end else if (mode_in == MODE_VALUE) begin
         push_cmd.end_status = STATUS_OPEN_VALUE;
      end else begin
         push_cmd.end_status = STATUS_DONE;
      end
      push_cmd.pair_index = pcount_ff;
      push_cmd.end_count = pcount_in;
      push_cmd.key_open = to_field(kopen_in);
      push_cmd.quote_pos = to_field(qcand_in);
      push_cmd.value_start = to_field(vstart_in);
      push_cmd.close_pos = to_field(cur_pos);
      push = accept && (has_pair || req.last_byte);

      // the last byte returns the scanner to its reset state
      if (accept && req.last_byte) begin
         mode_in = MODE_SEEK;
         fpos_in = '0;
         kopen_in = '0;
         qcand_in = '0;
         vstart_in = '0;
         pcount_in = '0;
         ovf_in = 1'b0;
         ended_in = 1'b0;
         pquote_in = 1'b0;
         pqcolon_in = 1'b0;
      end
   end

endmodule

// ----- sv/fjkv_queue.sv -----
// short queue of scan results between front and back
module fjkv_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  fjkv_pkg::scan_cmd_type push_cmd,
   input  logic pop,
   output fjkv_pkg::scan_cmd_type head_cmd,
   output logic empty,
   output logic full
);
   import fjkv_pkg::*;

   scan_cmd_type mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QUEUE_PTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign empty = (count_ff == '0);
   assign full = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head_cmd = mem[rptr_ff];

   // pointer and fill count update
   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/fjkv_back.sv -----
// back end: turns queue entries into result words in an output register
module fjkv_back (
   input  logic clock,
   input  logic reset,
   input  logic empty,
   input  fjkv_pkg::scan_cmd_type head_cmd,
   output logic pop,
   fjkv_rsp_if.source rsp
);
   import fjkv_pkg::*;

   logic rsp_valid_ff, rsp_valid_in;
   logic pair_sent_ff, pair_sent_in;
   logic [1:0] status_ff, status_in;
   logic [FIELD_BITS-1:0] index_ff, index_in;
   logic [FIELD_BITS-1:0] koff_ff, koff_in;
   logic [FIELD_BITS-1:0] klen_ff, klen_in;
   logic [FIELD_BITS-1:0] voff_ff, voff_in;
   logic [FIELD_BITS-1:0] vlen_ff, vlen_in;
   logic final_ff, final_in;
   logic load;
   logic take;
   logic emit_pair;

   assign load = !rsp_valid_ff || rsp.ready;
   assign take = load && !empty;
   assign emit_pair = head_cmd.has_pair && !pair_sent_ff;
   assign pop = take && !(emit_pair && head_cmd.has_end);

   // result word selection and control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pair_sent_in = pair_sent_ff;
      status_in = status_ff;
      index_in = index_ff;
      koff_in = koff_ff;
      klen_in = klen_ff;
      voff_in = voff_ff;
      vlen_in = vlen_ff;
      final_in = final_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         pair_sent_in = emit_pair && head_cmd.has_end;
         if (emit_pair) begin
            status_in = STATUS_PAIR;
            index_in = head_cmd.pair_index;
            koff_in = head_cmd.key_open + 1'b1;
            klen_in = head_cmd.quote_pos - head_cmd.key_open - 1'b1;
            voff_in = head_cmd.value_start;
            vlen_in = head_cmd.close_pos - head_cmd.value_start;
            final_in = 1'b0;
         end else begin
            status_in = head_cmd.end_status;
            index_in = head_cmd.end_count;
            koff_in = '0;
            klen_in = '0;
            voff_in = '0;
            vlen_in = '0;
            final_in = 1'b1;
         end
      end else if (load) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pair_sent_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pair_sent_ff <= pair_sent_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      index_ff <= index_in;
      koff_ff <= koff_in;
      klen_ff <= klen_in;
      voff_ff <= voff_in;
      vlen_ff <= vlen_in;
      final_ff <= final_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.pair_index = index_ff;
   assign rsp.key_offset = koff_ff;
   assign rsp.key_length = klen_ff;
   assign rsp.value_offset = voff_ff;
   assign rsp.value_length = vlen_ff;
   assign rsp.final_res = final_ff;

endmodule

// ----- sv/flat_json_key_value_scanner_core.sv -----
// top level of the flat json key value scanner
// Usage:
//   req_bus takes one raw message byte per word, with last_byte marking the
//   final byte of the buffer. Bytes outside 0x21..0x7E are dropped, a zero
//   byte ends the message, and later bytes up to last_byte are ignored.
//   rsp_bus gives one word per key value pair found (status 0), and one end
//   word with final_res set on the last byte (done, unterminated value or
//   overflow) carrying the pair count in pair_index.
// Throughput: one byte per cycle while the result queue is not full. A
//   byte that both closes a pair and ends the message yields two words,
//   which leave the output register one after the other; the four-entry
//   result queue absorbs that. An accepted byte's words are written into
//   the result queue, then loaded from it into the output register.
// Stall: when rsp_bus is held off the output register keeps its word, the
//   queue fills, and req_bus.ready drops once the queue is full.
// Reset: synchronous; clears scan state, queue and output valid. The last
//   byte of each message also returns the scanner to its reset state.
module flat_json_key_value_scanner_core #(
   parameter int POSITION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   fjkv_req_if.sink req_bus,
   fjkv_rsp_if.source rsp_bus
);
   import fjkv_pkg::*;

   logic q_push;
   logic q_pop;
   logic q_empty;
   logic q_full;
   scan_cmd_type q_push_cmd;
   scan_cmd_type q_head_cmd;

   // byte scan
   fjkv_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .queue_full(q_full),
      .push(q_push),
      .push_cmd(q_push_cmd)
   );

   // result queue
   fjkv_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_cmd(q_push_cmd),
      .pop(q_pop),
      .head_cmd(q_head_cmd),
      .empty(q_empty),
      .full(q_full)
   );

   // result words
   fjkv_back u_back (
      .clock(clock),
      .reset(reset),
      .empty(q_empty),
      .head_cmd(q_head_cmd),
      .pop(q_pop),
      .rsp(rsp_bus)
   );

   // no queue write while the queue is full
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("result queue written while full");

   // end words and only end words carry a non-pair status
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.final_res == (rsp_bus.status != STATUS_PAIR)))
      else $error("final flag and status disagree");

   // end words carry zero offsets and lengths
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.final_res) |->
         (rsp_bus.key_offset == '0 && rsp_bus.key_length == '0 &&
          rsp_bus.value_offset == '0 && rsp_bus.value_length == '0))
      else $error("end word with nonzero pair fields");

   // output is empty right after reset
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule

// ----- verif/tb_flat_json_key_value_scanner_core.sv -----
// testbench of the flat json key value scanner: byte stimulus, pair and end report checks
`timescale 1ns / 1ps

module tb_flat_json_key_value_scanner_core;
   import fjkv_pkg::*;

   localparam int POS_BITS = 16;
   localparam int unsigned POS_LIMIT = (1 << POS_BITS) - 1;
   localparam int RANDOM_BYTES = 1725;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;

   // one result word as seen on the response channel
   typedef struct packed {
      status_type status;
      logic [15:0] pair_index;
      logic [15:0] key_offset;
      logic [15:0] key_length;
      logic [15:0] value_offset;
      logic [15:0] value_length;
      logic final_res;
   } pair_report_type;

   // tracks the scan state and holds the reports still to come
   class kv_report_tracker;
      scan_mode_type mode;
      int unsigned fpos;
      int unsigned key_open;
      int unsigned quote_pos;
      int unsigned value_start;
      logic [15:0] pair_count;
      bit overflowed;
      bit ended;
      bit saw_quote;
      bit saw_quote_colon;
      pair_report_type pending_reports[$];
      int errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         mode = MODE_SEEK;
         fpos = 0;
         key_open = 0;
         quote_pos = 0;
         value_start = 0;
         pair_count = '0;
         overflowed = 1'b0;
         ended = 1'b0;
         saw_quote = 1'b0;
         saw_quote_colon = 1'b0;
      endfunction

      // advance the scan by one accepted byte and queue the reports it causes
      function void scan_byte(logic [7:0] c, logic last);
         int unsigned q;
         pair_report_type r;
         if (!ended && !overflowed) begin
            if (c == CHAR_NUL) begin
               ended = 1'b1;
            end else if (c > CHAR_SPACE && c <= CHAR_TILDE) begin
               if (fpos >= POS_LIMIT) begin
                  overflowed = 1'b1;
               end else begin
                  q = fpos;
                  fpos = q + 1;
                  case (mode)
                     MODE_SEEK: begin
                        if (c == CHAR_QUOTE) begin
                           key_open = q;
                           saw_quote = 1'b0;
                           saw_quote_colon = 1'b0;
                           mode = MODE_KEY;
                        end
                     end
                     MODE_KEY: begin
                        if (saw_quote_colon) begin
                           // a key whose value is an object gives no pair; its inner keys are scanned
                           if (c == CHAR_LBRACE) begin
                              mode = MODE_SEEK;
                           end else begin
                              quote_pos = q - 2;
                              value_start = q;
                              mode = MODE_VALUE;
                           end
                           saw_quote = 1'b0;
                           saw_quote_colon = 1'b0;
                        end else begin
                           saw_quote_colon = saw_quote && (c == CHAR_COLON);
                           saw_quote = (c == CHAR_QUOTE);
                        end
                     end
                     default: ;
                  endcase
                  // value closes on comma or closing brace, possibly on its first byte
                  if (mode == MODE_VALUE && (c == CHAR_COMMA || c == CHAR_RBRACE)) begin
                     r.status = STATUS_PAIR;
                     r.pair_index = pair_count;
                     r.key_offset = 16'(key_open + 1);
                     r.key_length = 16'(quote_pos - key_open - 1);
                     r.value_offset = 16'(value_start);
                     r.value_length = 16'(q - value_start);
                     r.final_res = 1'b0;
                     pending_reports.push_back(r);
                     pair_count = pair_count + 16'd1;
                     mode = MODE_SEEK;
                  end
               end
            end
         end
         // end report closes the message and clears the scan
         if (last) begin
            if (overflowed)
               r.status = STATUS_OVERFLOW;
            else if (mode == MODE_VALUE)
               r.status = STATUS_OPEN_VALUE;
            else
               r.status = STATUS_DONE;
            r.pair_index = pair_count;
            r.key_offset = '0;
            r.key_length = '0;
            r.value_offset = '0;
            r.value_length = '0;
            r.final_res = 1'b1;
            pending_reports.push_back(r);
            restart();
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
         end
      endfunction

      // compare one accepted result word with the oldest pending report
      function void check_result(pair_report_type got);
         pair_report_type want;
         if (pending_reports.size() == 0) begin
            $error("unexpected word: status %0d pair_index %0d final_res %0d",
                   got.status, got.pair_index, got.final_res);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("pair_index", want.pair_index, got.pair_index);
         compare_field("key_offset", want.key_offset, got.key_offset);
         compare_field("key_length", want.key_length, got.key_length);
         compare_field("value_offset", want.value_offset, got.value_offset);
         compare_field("value_length", want.value_length, got.value_length);
         compare_field("final_res", want.final_res, got.final_res);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   fjkv_req_if req_bus ();
   fjkv_rsp_if rsp_bus ();

   flat_json_key_value_scanner_core #(
      .POSITION_BITS(POS_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   kv_report_tracker reports;
   pair_report_type seen;
   int send_idle_pct;
   int rsp_idle_pct;
   int holds_asked;
   int holds_done;
   int hold_left;
   int quiet_cycles;
   int bytes_sent;

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: check accepted words, drive ready with random stalls and long holds
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.status = status_type'(rsp_bus.status);
         seen.pair_index = rsp_bus.pair_index;
         seen.key_offset = rsp_bus.key_offset;
         seen.key_length = rsp_bus.key_length;
         seen.value_offset = rsp_bus.value_offset;
         seen.value_length = rsp_bus.value_length;
         seen.final_res = rsp_bus.final_res;
         reports.check_result(seen);
      end
      if (holds_done != holds_asked) begin
         hold_left = HOLD_CYCLES;
         holds_done = holds_asked;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("flat_json_key_value_scanner_core: mismatch");
            $finish;
         end
      end
   end

   // offer one byte, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_byte(input logic [7:0] b, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      reports.scan_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_message(input logic [7:0] msg[$]);
      for (int i = 0; i < msg.size(); i++)
         send_byte(msg[i], i == msg.size() - 1);
   endtask

   // bytes the scanner drops, never the terminating zero
   function automatic void add_junk(ref logic [7:0] q[$]);
      while ($urandom_range(99) < 15)
         q.push_back($urandom_range(1) ? 8'($urandom_range(1, 32))
                                       : 8'($urandom_range(127, 255)));
   endfunction

   function automatic logic [7:0] key_char();
      logic [7:0] c;
      c = 8'($urandom_range(33, 126));
      if (c == CHAR_QUOTE && $urandom_range(3) != 0)
         c = 8'h6B;
      return c;
   endfunction

   function automatic logic [7:0] value_char();
      logic [7:0] c;
      c = 8'($urandom_range(33, 126));
      if ((c == CHAR_COMMA || c == CHAR_RBRACE) && $urandom_range(7) != 0)
         c = 8'h37;
      return c;
   endfunction

   // "key":value or "key":{ inner pairs }
   function automatic void add_pair(ref logic [7:0] q[$], input bit nest);
      int n;
      add_junk(q);
      q.push_back(CHAR_QUOTE);
      n = $urandom_range(0, 5);
      repeat (n) q.push_back(key_char());
      q.push_back(CHAR_QUOTE);
      add_junk(q);
      q.push_back(CHAR_COLON);
      add_junk(q);
      if (nest && $urandom_range(9) == 0) begin
         q.push_back(CHAR_LBRACE);
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            if (i != 0) q.push_back(CHAR_COMMA);
            add_pair(q, 1'b0);
         end
         q.push_back(CHAR_RBRACE);
      end else begin
         n = $urandom_range(0, 6);
         repeat (n) q.push_back(value_char());
      end
   endfunction

   // mostly well-formed objects, some cut short, some with a zero byte, some noise
   task automatic send_random_message();
      logic [7:0] msg[$];
      int kind;
      int n;
      int at;
      kind = $urandom_range(99);
      if (kind < 88) begin
         add_junk(msg);
         msg.push_back(CHAR_LBRACE);
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            if (i != 0) msg.push_back(CHAR_COMMA);
            add_pair(msg, 1'b1);
         end
         msg.push_back(CHAR_RBRACE);
         add_junk(msg);
         if (kind >= 70 && kind < 80) begin
            at = $urandom_range(1, msg.size());
            while (msg.size() > at) void'(msg.pop_back());
         end else if (kind >= 80) begin
            at = $urandom_range(0, msg.size() - 1);
            msg[at] = CHAR_NUL;
            n = $urandom_range(0, 4);
            repeat (n) msg.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         n = $urandom_range(1, 20);
         repeat (n) msg.push_back(8'($urandom_range(0, 255)));
      end
      send_message(msg);
   endtask

   // stimulus and end of run
   initial begin
      logic [7:0] msg[$];
      int start;
      reports = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 15;
      rsp_idle_pct = 59;
      holds_asked = 0;
      holds_done = 0;
      hold_left = 0;
      quiet_cycles = 0;
      bytes_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // {"a":1} with the pair and the end report on the closing brace
      msg = '{CHAR_LBRACE, CHAR_QUOTE, 8'h61, CHAR_QUOTE, CHAR_COLON, 8'h31, CHAR_RBRACE};
      send_message(msg);
      // object-valued key gives no pair, its inner value left open; boundary characters kept/dropped
      msg = '{CHAR_SPACE, CHAR_QUOTE, 8'h6B, CHAR_QUOTE, CHAR_COLON, CHAR_LBRACE,
              CHAR_QUOTE, CHAR_TILDE, CHAR_QUOTE, CHAR_COLON, 8'h7F, 8'hFF, 8'h21};
      send_message(msg);
      // zero byte ends the message inside an unclosed key, later bytes ignored
      msg = '{CHAR_QUOTE, CHAR_NUL, CHAR_QUOTE, 8'h01};
      send_message(msg);

      // random messages over three idle patterns
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         if (send_idle_pct == 15 && bytes_sent - start >= RANDOM_BYTES / 3) begin
            send_idle_pct = 59;
            rsp_idle_pct <= 15;
         end else if (send_idle_pct == 59 && bytes_sent - start >= 2 * RANDOM_BYTES / 3) begin
            send_idle_pct = 0;
            rsp_idle_pct <= 0;
            // long receiver hold while the sender keeps offering
            holds_asked <= holds_asked + 1;
         end
         send_random_message();
      end

      req_bus.valid <= 1'b0;
      while (reports.pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (reports.errors == 0 && reports.pending_reports.size() == 0)
         $display("flat_json_key_value_scanner_core: match");
      else
         $display("flat_json_key_value_scanner_core: mismatch");
      $finish;
   end

endmodule
